// ===== rtl/core/sand_pkg.sv =====
// Shared types, constants and configuration register codes for the SAND-128 block cipher.
package sand_pkg;

   localparam int MAX_ROUNDS_DEF = 64;
   localparam int CSR_INDEX_W    = 8;
   localparam int ROUND_COUNT_W  = 7;
   localparam logic [ROUND_COUNT_W-1:0] ROUND_COUNT_RESET = 7'd54;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LOW      = 8'd0,
      CSR_KEY_HIGH     = 8'd1,
      CSR_ROUND_COUNT  = 8'd2,
      CSR_DECRYPT_MODE = 8'd3
   } csr_index_type;

   localparam logic [63:0] MASK_EVEN_BYTES = 64'h00FF00FF00FF00FF;
   localparam logic [63:0] MASK_ODD_BYTES  = 64'hFF00FF00FF00FF00;
   localparam logic [63:0] MASK_BIT0       = 64'h1111111111111111;
   localparam logic [63:0] MASK_BIT3       = 64'h8888888888888888;
   localparam logic [63:0] MASK_BIT2       = 64'h4444444444444444;
   localparam logic [63:0] MASK_BIT1       = 64'h2222222222222222;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

endpackage

// ===== rtl/core/sand_key_store.sv =====
// Round key memory with one write port and one registered read port.
module sand_key_store #(
   parameter int DEPTH = sand_pkg::MAX_ROUNDS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sand_round_fn.sv =====
// One Feistel round: nibble nonlinearity, byte permutation and round key mix.
module sand_round_fn (
   input  logic [63:0] x,
   input  logic [63:0] y,
   input  logic [63:0] round_key,
   output logic [63:0] y_next
);

   function automatic logic [63:0] nl_g0(input logic [63:0] v);
      logic [63:0] t;
      t = v ^ ((v >> 3) & (v >> 2) & sand_pkg::MASK_BIT0);
      t = t ^ ((t << 3) & (t << 2) & sand_pkg::MASK_BIT3);
      return t;
   endfunction

   function automatic logic [63:0] nl_g1(input logic [63:0] v);
      logic [63:0] t;
      t = v ^ ((v >> 1) & (v << 1) & sand_pkg::MASK_BIT2);
      t = t ^ ((t << 1) & (t >> 1) & sand_pkg::MASK_BIT1);
      return t;
   endfunction

   function automatic logic [63:0] perm_bytes(input logic [63:0] v);
      logic [63:0] a;
      logic [63:0] b;
      a = v & sand_pkg::MASK_EVEN_BYTES;
      b = v & sand_pkg::MASK_ODD_BYTES;
      return {a[7:0], a[63:8]} | {b[39:0], b[63:40]};
   endfunction

   logic [63:0] x_rot;

   assign x_rot  = {x[59:0], x[63:60]};
   assign y_next = y ^ perm_bytes(nl_g0(x) ^ nl_g1(x_rot)) ^ round_key;

endmodule

// ===== rtl/core/sand128_block_cipher.sv =====
// Top level of the SAND-128 block cipher: registers, sequencer and result register.
//
// Usage: configuration is written through csr_we, csr_index and csr_wdata while
// the block is idle; any write to a known register marks the round keys stale.
// A 128-bit block is a transfer on req_valid/req_stall; its result is a transfer
// on rsp_valid/rsp_stall. Blocks are independent (ECB).
// With n the effective round count (round_count limited to 2..MAX_ROUNDS),
// a block runs its n rounds and then loads its result into the output
// register; a new block is accepted only after that load. The single shared
// round unit does one round per cycle out of the key memory. The first block
// after reset or after a configuration write first expands the keys into
// the memory, one key per cycle. Reset clears the control state and the
// configuration to its defaults (54 rounds, encrypt, zero key). When the
// receiver stalls, the result stays in the output register; the next block
// is still accepted and runs, and holds its result until the register frees.
module sand128_block_cipher #(
   parameter int MAX_ROUNDS = sand_pkg::MAX_ROUNDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sand_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sand_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [sand_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_wdata
);

   localparam int AW    = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_PREFETCH,
      ST_ROUND,
      ST_DONE
   } state_type;

   function automatic logic [63:0] a16_triple(input logic [63:0] v);
      logic [63:0] t;
      logic [3:0]  n;
      t = v;
      for (int i = 0; i < 3; i++) begin
         t = {t[3:0], t[63:4]};
         n = t[59:56];
         t[63:60] = t[63:60] ^ {n[2:0], n[3]};
         t[59]    = t[59] ^ n[0];
      end
      return t;
   endfunction

   state_type                            state_ff, state_in;
   logic [63:0]                          key_low_ff, key_high_ff;
   logic [sand_pkg::ROUND_COUNT_W-1:0]   round_count_ff;
   logic                                 decrypt_ff;
   logic                                 keys_ready_ff, keys_ready_in;
   logic [CNT_W-1:0]                     n_ff, n_in;
   logic [CNT_W-1:0]                     cnt_ff, cnt_in;
   logic [63:0]                          x_ff, x_in, y_ff, y_in;
   logic [63:0]                          ka_ff, ka_in, kb_ff, kb_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   sand_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]                     eff_rounds;
   logic                                 csr_hit;
   logic                                 req_xfer;
   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic [AW-1:0]                        rd_addr;
   logic [63:0]                          rd_data;
   logic [63:0]                          y_next;

   always_comb begin
      priority if (round_count_ff < sand_pkg::ROUND_COUNT_W'(2)) begin
         eff_rounds = CNT_W'(2);
      end else if (int'(round_count_ff) > MAX_ROUNDS) begin
         eff_rounds = CNT_W'(MAX_ROUNDS);
      end else begin
         eff_rounds = CNT_W'(round_count_ff);
      end
   end

   assign csr_hit = csr_we && (csr_index == sand_pkg::CSR_KEY_LOW
                            || csr_index == sand_pkg::CSR_KEY_HIGH
                            || csr_index == sand_pkg::CSR_ROUND_COUNT
                            || csr_index == sand_pkg::CSR_DECRYPT_MODE);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign wr_en   = (state_ff == ST_EXPAND);
   assign wr_addr = decrypt_ff ? AW'(n_ff - cnt_ff - CNT_W'(1)) : AW'(cnt_ff);
   assign rd_addr = (state_ff == ST_ROUND) ? AW'(cnt_ff + CNT_W'(1)) : '0;

   sand_key_store #(
      .DEPTH (MAX_ROUNDS),
      .AW    (AW)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ka_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sand_round_fn u_round_fn (
      .x         (x_ff),
      .y         (y_ff),
      .round_key (rd_data),
      .y_next    (y_next)
   );

   always_comb begin
      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ka_in         = ka_ff;
      kb_in         = kb_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_in   = req_data.block_high;
               y_in   = req_data.block_low;
               n_in   = eff_rounds;
               cnt_in = '0;
               ka_in  = key_low_ff;
               kb_in  = key_high_ff;
               state_in = keys_ready_ff ? ST_PREFETCH : ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            ka_in  = kb_ff;
            kb_in  = a16_triple(kb_ff) ^ ka_ff ^ 64'(cnt_ff + CNT_W'(1));
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == n_ff - CNT_W'(1)) begin
               keys_ready_in = 1'b1;
               state_in      = ST_PREFETCH;
            end
         end
         ST_PREFETCH: begin
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            x_in   = y_next;
            y_in   = x_ff;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == n_ff - CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_low  = x_ff;
               rsp_data_in.result_high = y_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_hit) begin
         keys_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         keys_ready_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         key_low_ff     <= '0;
         key_high_ff    <= '0;
         round_count_ff <= sand_pkg::ROUND_COUNT_RESET;
         decrypt_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               sand_pkg::CSR_KEY_LOW:      key_low_ff     <= csr_wdata;
               sand_pkg::CSR_KEY_HIGH:     key_high_ff    <= csr_wdata;
               sand_pkg::CSR_ROUND_COUNT:
                  round_count_ff <= csr_wdata[sand_pkg::ROUND_COUNT_W-1:0];
               sand_pkg::CSR_DECRYPT_MODE: decrypt_ff     <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ka_ff       <= ka_in;
      kb_ff       <= kb_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_csr_clears_keys: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> !keys_ready_ff)
      else $error("Round keys still marked ready after a register write.");

   a_round_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND || state_ff == ST_EXPAND) |-> (cnt_ff < n_ff))
      else $error("Round or expansion counter ran past the round count.");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("Result register loaded outside the completion state.");

   a_rounds_need_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREFETCH) |-> keys_ready_ff)
      else $error("Rounds started without expanded keys.");
`endif

endmodule
